// ===== rtl/core/itoa_pkg.sv =====
// shared types, constants and the digit-to-character function of the
// integer to ascii formatter; no dependencies
package itoa_pkg;

    localparam int VALUE_W        = 64;
    localparam int VALUE_BITS_DEF = 64;
    localparam int DEC_DIGITS     = 20;
    localparam int OCT_DIGITS     = 11;
    localparam int IDX_W          = 5;

    localparam logic [2:0] OP_UDEC = 3'd0;
    localparam logic [2:0] OP_SDEC = 3'd1;
    localparam logic [2:0] OP_HEX  = 3'd2;
    localparam logic [2:0] OP_BIN  = 3'd3;
    localparam logic [2:0] OP_OCT  = 3'd4;

    localparam logic [6:0] CHAR_MINUS = 7'h2D;
    localparam logic [6:0] CHAR_ZERO  = 7'h30;
    localparam logic [6:0] CHAR_UPPER = 7'h37;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } itoa_state_t;

    typedef struct packed {
        logic clear;
        logic dabble;
        logic shift;
    } cell_ctrl_t;

    function automatic logic [6:0] digit_char(input logic [3:0] d);
        logic [6:0] c;
        if (d < 4'd10)
            c = CHAR_ZERO + 7'(d);
        else
            c = CHAR_UPPER + 7'(d);
        return c;
    endfunction

endpackage

// ===== rtl/core/integer_to_ascii_formatter.sv =====
// top level of the integer to ascii formatter: command control, operand
// masking, the chain of bcd cells and the character output; uses itoa_pkg
// and itoa_bcd_cell
//
// A number is taken when start is high and busy is low; busy drops in the cycle
// that carries its last character on char_out, so the next number can be taken
// at the edge that ends that cycle. Characters leave one per cycle on char_out,
// marked by strobe, and the final one of a number carries last; the receiver
// cannot hold them off. Decimal formats first shift the operand, top bit first,
// through a row of 20 bcd digit cells with shift-add-3, then skip suppressed
// leading zeros one per cycle and emit the digits, after a minus sign if one is
// needed. Octal emits 11 digits with leading zeros skipped one per cycle, hex
// emits 2, 4, 8 or 16 digits and binary 8, with no zeros skipped. Format
// codes above octal are taken and ignored.
module integer_to_ascii_formatter #(
    parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [2:0]                   op,
    input  logic [1:0]                   size,
    input  logic [itoa_pkg::VALUE_W-1:0] value,
    output logic                         strobe,
    output logic [6:0]                   char_out,
    output logic                         last
);
    import itoa_pkg::*;

    localparam int CNT_W = $clog2(VALUE_BITS);

    itoa_state_t state_reg, state_next;
    logic [2:0]            op_reg, op_next;
    logic                  neg_reg, neg_next;
    logic [VALUE_BITS-1:0] work_reg, work_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic                  strobe_reg, strobe_next;
    logic [6:0]            char_reg, char_next;
    logic                  last_reg, last_next;

    cell_ctrl_t            cctl;
    logic [DEC_DIGITS-1:0] bit_chain;
    logic [3:0]            digits [DEC_DIGITS];

    logic [VALUE_W-1:0]    mask64;
    logic [VALUE_BITS-1:0] mask;
    logic [VALUE_BITS-1:0] operand;
    logic [VALUE_BITS-1:0] mag;
    logic [6:0]            opw;
    logic                  sign_bit;
    logic [VALUE_W-1:0]    work_ext;
    logic [6:0]            oct_sh;
    logic [3:0]            cur;
    logic                  is_dec;

    genvar g;
    generate
        for (g = 0; g < DEC_DIGITS; g++)
        begin : g_cell
            logic       b_in;
            logic [3:0] n_in;
            if (g == 0)
            begin : g_first
                assign b_in = work_reg[VALUE_BITS-1];
                assign n_in = 4'd0;
            end
            else
            begin : g_rest
                assign b_in = bit_chain[g-1];
                assign n_in = digits[g-1];
            end
            itoa_bcd_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctrl    (cctl),
                .bit_in  (b_in),
                .nib_in  (n_in),
                .bit_out (bit_chain[g]),
                .digit   (digits[g])
            );
        end
    endgenerate

    // operand masking and magnitude
    always_comb
    begin
        case (size)
            2'd0:    mask64 = 64'h0000_0000_0000_00FF;
            2'd1:    mask64 = 64'h0000_0000_0000_FFFF;
            2'd2:    mask64 = 64'h0000_0000_FFFF_FFFF;
            default: mask64 = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        if (op == OP_BIN)
            mask64 = 64'h0000_0000_0000_00FF;
        else if (op == OP_OCT)
            mask64 = 64'h0000_0000_FFFF_FFFF;
        mask    = VALUE_BITS'(mask64);
        operand = VALUE_BITS'(value) & mask;
        opw     = 7'd8 << size;
        if (opw > 7'(VALUE_BITS))
            opw = 7'(VALUE_BITS);
        sign_bit = |(operand >> (opw - 7'd1)) & 1'b1;
        mag      = (~operand + VALUE_BITS'(1)) & mask;
    end

    assign work_ext = VALUE_W'(work_reg);
    assign oct_sh   = 7'(idx_reg) * 7'd3;
    assign is_dec   = (op_reg == OP_UDEC) || (op_reg == OP_SDEC);

    always_comb
    begin
        case (op_reg)
            OP_UDEC: cur = digits[DEC_DIGITS-1];
            OP_SDEC: cur = digits[DEC_DIGITS-1];
            OP_HEX:  cur = 4'(work_ext >> {idx_reg, 2'b00});
            OP_BIN:  cur = {3'b000, work_ext[idx_reg[2:0]]};
            OP_OCT:  cur = 4'(work_ext >> oct_sh) & 4'h7;
            default: cur = 4'd0;
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        neg_next    = neg_reg;
        work_next   = work_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        strobe_next = 1'b0;
        char_next   = char_reg;
        last_next   = 1'b0;
        cctl        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next  = op;
                    neg_next = 1'b0;
                    cnt_next = '0;
                    case (op)
                        OP_UDEC:
                        begin
                            work_next  = operand;
                            cctl.clear = 1'b1;
                            state_next = ST_CONV;
                        end
                        OP_SDEC:
                        begin
                            neg_next   = sign_bit;
                            work_next  = sign_bit ? mag : operand;
                            cctl.clear = 1'b1;
                            state_next = ST_CONV;
                        end
                        OP_HEX:
                        begin
                            work_next  = operand;
                            idx_next   = IDX_W'(5'd2 << size) - IDX_W'(1);
                            state_next = ST_EMIT;
                        end
                        OP_BIN:
                        begin
                            work_next  = operand;
                            idx_next   = IDX_W'(7);
                            state_next = ST_EMIT;
                        end
                        OP_OCT:
                        begin
                            work_next  = operand;
                            idx_next   = IDX_W'(OCT_DIGITS - 1);
                            state_next = ST_SKIP;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CONV:
            begin
                cctl.dabble = 1'b1;
                work_next   = work_reg << 1;
                cnt_next    = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(VALUE_BITS - 1))
                begin
                    idx_next   = IDX_W'(DEC_DIGITS - 1);
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if (cur == 4'd0 && idx_reg != '0)
                begin
                    idx_next   = idx_reg - IDX_W'(1);
                    cctl.shift = is_dec;
                end
                else
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
            end
            ST_SIGN:
            begin
                strobe_next = 1'b1;
                char_next   = CHAR_MINUS;
                state_next  = ST_EMIT;
            end
            ST_EMIT:
            begin
                strobe_next = 1'b1;
                char_next   = digit_char(cur);
                if (idx_reg == '0)
                begin
                    last_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg - IDX_W'(1);
                    cctl.shift = is_dec;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            op_reg     <= OP_UDEC;
            neg_reg    <= 1'b0;
            work_reg   <= '0;
            cnt_reg    <= '0;
            idx_reg    <= '0;
            strobe_reg <= 1'b0;
            char_reg   <= '0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            op_reg     <= op_next;
            neg_reg    <= neg_next;
            work_reg   <= work_next;
            cnt_reg    <= cnt_next;
            idx_reg    <= idx_next;
            strobe_reg <= strobe_next;
            char_reg   <= char_next;
            last_reg   <= last_next;
        end
    end

    assign busy     = (state_reg != ST_IDLE);
    assign strobe   = strobe_reg;
    assign char_out = char_reg;
    assign last     = last_reg;

endmodule

// ===== rtl/core/itoa_bcd_cell.sv =====
// one bcd digit cell of the conversion chain: add-3 and bit shift during
// conversion, nibble shift toward the top during output; uses itoa_pkg
module itoa_bcd_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  itoa_pkg::cell_ctrl_t ctrl,
    input  logic                 bit_in,
    input  logic [3:0]           nib_in,
    output logic                 bit_out,
    output logic [3:0]           digit
);
    import itoa_pkg::*;

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] adj;

    assign adj     = (digit_reg >= 4'd5) ? digit_reg + 4'd3 : digit_reg;
    assign bit_out = adj[3];
    assign digit   = digit_reg;

    always_comb
    begin
        digit_next = digit_reg;
        if (ctrl.clear)
            digit_next = 4'd0;
        else if (ctrl.dabble)
            digit_next = {adj[2:0], bit_in};
        else if (ctrl.shift)
            digit_next = nib_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            digit_reg <= 4'd0;
        else
            digit_reg <= digit_next;
    end

endmodule
